// File: design/bps_pkg.sv
// Shared constants, types and helpers for the bilinear pixel sampler.
package bps_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;

  localparam int CH_W      = 16;
  localparam int PIX_W     = 4 * CH_W;
  localparam int ADDR_W    = 16;
  localparam int COORD_W   = 18;
  localparam int CFG_DIM_W = 9;
  localparam int INT_W     = COORD_W - FRAC_BITS;
  localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SIZE_W    = $clog2(MAX_DIM + 1);
  localparam int POS_W     = $clog2(MAX_DIM);
  localparam int WGT_W     = FRAC_BITS + 1;
  localparam int WT_W      = 2 * FRAC_BITS + 1;
  localparam int ACC_W     = CH_W + 2 * FRAC_BITS;

  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 4;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SIXTEEN_BIT  = 2'd2;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_LAST,
    ST_DONE
  } state_e;

  // A size of zero acts as one; sizes above the maximum saturate.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_DIM_W-1:0] v,
                                                   input int max_v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (int'(v) > max_v) begin
      r = SIZE_W'(max_v);
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

  // Clamp a signed neighbour position to the range [0, size-1].
  function automatic logic [POS_W-1:0] clamp_pos(input logic signed [INT_W:0] p,
                                                 input logic [SIZE_W-1:0] size);
    logic [POS_W-1:0] r;
    if (p < 0) begin
      r = '0;
    end else if (int'(p) >= int'(size)) begin
      r = POS_W'(size - SIZE_W'(1));
    end else begin
      r = POS_W'(unsigned'(p));
    end
    return r;
  endfunction

endpackage

// File: design/bilinear_pixel_sampler_unit.sv
// Bilinear RGBA pixel sampler: pixel store, sample sequencer and APB registers.

// The block keeps a 65536-entry image of 64-bit BGRA pixels in a single-port
// synchronous memory. A write item (req_type 0) stores one pixel. A sample item
// (req_type 1) clamps the neighbour columns and rows, then forms the two row
// base addresses and the four bilinear weights, then reads the four neighbours
// through the single memory port (one read per cycle, each multiply-accumulated
// the cycle after), then adds the last product, and last clamps and hands off
// the result. The result sits in an output register, so the next item is taken
// while it waits; the hand-off cycle repeats while an earlier result is still
// not accepted. Pixels are undefined until written. The user must write the
// registers over APB only while the block is idle; the block itself does
// not enforce this.
module bilinear_pixel_sampler_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [bps_pkg::ADDR_W-1:0]     pixel_index_i,
  input  logic [bps_pkg::CH_W-1:0]       in_blue_i,
  input  logic [bps_pkg::CH_W-1:0]       in_green_i,
  input  logic [bps_pkg::CH_W-1:0]       in_red_i,
  input  logic [bps_pkg::CH_W-1:0]       in_alpha_i,
  input  logic signed [bps_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [bps_pkg::COORD_W-1:0] coord_y_i,

  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bps_pkg::CH_W-1:0]       out_blue_o,
  output logic [bps_pkg::CH_W-1:0]       out_green_o,
  output logic [bps_pkg::CH_W-1:0]       out_red_o,
  output logic [bps_pkg::CH_W-1:0]       out_alpha_o,

  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bps_pkg::PADDR_W-1:0]    paddr,
  input  logic [bps_pkg::APB_DW-1:0]     pwdata,
  output logic [bps_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import bps_pkg::*;

  // Configuration registers
  logic [CFG_DIM_W-1:0] cfg_width_q, cfg_height_q;
  logic                 cfg_sixteen_q;
  logic                 cfg_we;
  logic [1:0]           cfg_idx;

  // Control
  state_e     state_q, state_d;
  logic [1:0] rd_cnt_q, rd_cnt_d;
  logic       in_ready, coord_load, mem_we, addr_load, rd_en, out_load;
  logic       out_free;

  // Sample datapath
  logic [SIZE_W-1:0]       w_eff, h_eff;
  logic signed [INT_W:0]   ix0, ix1, iy0, iy1;
  logic [POS_W-1:0]        col_q [2];
  logic [POS_W-1:0]        row_q [2];
  logic [FRAC_BITS-1:0]    fx_q, fy_q;
  logic [WGT_W-1:0]        wx [2];
  logic [WGT_W-1:0]        wy [2];
  logic [ADDR_W-1:0]       base_q [2];
  logic [WT_W-1:0]         wt_q [4];
  logic [ADDR_W-1:0]       raddr;

  // Pixel store
  logic [PIX_W-1:0]        pixel_mem [2**ADDR_W];
  logic [PIX_W-1:0]        rdata_q;
  logic                    acc_en_q;
  logic [1:0]              acc_sel_q;
  logic [ACC_W-1:0]        sum_q [4];

  logic                    out_valid_q;
  logic [CH_W-1:0]         out_ch_q [4];
  logic [CH_W-1:0]         lim;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q   <= CFG_DIM_W'(256);
      cfg_height_q  <= CFG_DIM_W'(256);
      cfg_sixteen_q <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  cfg_width_q   <= pwdata[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height_q  <= pwdata[CFG_DIM_W-1:0];
        REG_SIXTEEN_BIT:  cfg_sixteen_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(cfg_width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(cfg_height_q);
      REG_SIXTEEN_BIT:  prdata = APB_DW'(cfg_sixteen_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && req_type_i == REQ_SAMPLE) state_d = ST_ADDR;
      end
      ST_ADDR: begin
        state_d  = ST_READ;
        rd_cnt_d = '0;
      end
      ST_READ: begin
        rd_cnt_d = rd_cnt_q + 2'd1;
        if (rd_cnt_q == 2'd3) state_d = ST_LAST;
      end
      ST_LAST: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    addr_load  = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready  = 1'b1;
      ST_ADDR:  addr_load = 1'b1;
      ST_READ:  rd_en     = 1'b1;
      ST_LAST:  ;
      ST_DONE:  out_load  = out_free;
      default:  ;
    endcase
  end

  assign in_ready_o = in_ready;
  assign coord_load = in_valid_i & in_ready & (req_type_i == REQ_SAMPLE);
  assign mem_we     = in_valid_i & in_ready & (req_type_i == REQ_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_cnt_q  <= '0;
      acc_en_q  <= 1'b0;
      acc_sel_q <= '0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      acc_en_q  <= rd_en;
      acc_sel_q <= rd_cnt_q;
    end
  end

  // ---------------------------------------------------------------- neighbours
  assign w_eff = clamp_size(cfg_width_q, MAX_WIDTH);
  assign h_eff = clamp_size(cfg_height_q, MAX_HEIGHT);

  // An arithmetic shift takes the floor of the coordinate.
  assign ix0 = (INT_W + 1)'(coord_x_i >>> FRAC_BITS);
  assign iy0 = (INT_W + 1)'(coord_y_i >>> FRAC_BITS);
  assign ix1 = ix0 + (INT_W + 1)'(1);
  assign iy1 = iy0 + (INT_W + 1)'(1);

  always_ff @(posedge clk_i) begin
    if (coord_load) begin
      col_q[0] <= clamp_pos(ix0, w_eff);
      col_q[1] <= clamp_pos(ix1, w_eff);
      row_q[0] <= clamp_pos(iy0, h_eff);
      row_q[1] <= clamp_pos(iy1, h_eff);
      fx_q     <= coord_x_i[FRAC_BITS-1:0];
      fy_q     <= coord_y_i[FRAC_BITS-1:0];
    end
  end

  assign wx[0] = WGT_W'(1 << FRAC_BITS) - WGT_W'(fx_q);
  assign wx[1] = WGT_W'(fx_q);
  assign wy[0] = WGT_W'(1 << FRAC_BITS) - WGT_W'(fy_q);
  assign wy[1] = WGT_W'(fy_q);

  // Read k covers column k[0] of row k[1].
  always_ff @(posedge clk_i) begin
    if (addr_load) begin
      base_q[0] <= ADDR_W'(row_q[0]) * ADDR_W'(w_eff);
      base_q[1] <= ADDR_W'(row_q[1]) * ADDR_W'(w_eff);
      for (int k = 0; k < 4; k++) begin
        wt_q[k] <= WT_W'(wx[k % 2]) * WT_W'(wy[k / 2]);
      end
    end
  end

  assign raddr = base_q[rd_cnt_q[1]] + ADDR_W'(col_q[rd_cnt_q[0]]);

  // ---------------------------------------------------------------- pixel store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pixel_mem[pixel_index_i] <= {in_alpha_i, in_red_i, in_green_i, in_blue_i};
    end
    if (rd_en) begin
      rdata_q <= pixel_mem[raddr];
    end
  end

  // ---------------------------------------------------------------- accumulate
  always_ff @(posedge clk_i) begin
    if (addr_load) begin
      for (int c = 0; c < 4; c++) sum_q[c] <= '0;
    end else if (acc_en_q) begin
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= sum_q[c] + ACC_W'(rdata_q[c*CH_W +: CH_W]) * ACC_W'(wt_q[acc_sel_q]);
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign lim = cfg_sixteen_q ? {CH_W{1'b1}} : CH_W'(255);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int c = 0; c < 4; c++) begin
        if (sum_q[c][ACC_W-1:2*FRAC_BITS] > lim) begin
          out_ch_q[c] <= lim;
        end else begin
          out_ch_q[c] <= sum_q[c][ACC_W-1:2*FRAC_BITS];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_blue_o  = out_ch_q[0];
  assign out_green_o = out_ch_q[1];
  assign out_red_o   = out_ch_q[2];
  assign out_alpha_o = out_ch_q[3];

endmodule
